// ===== hdl/edsim_pkg.sv =====
package edsim_pkg;

   // Field widths of the request and response words
   localparam int CH_W   = 8;
   localparam int CMD_W  = 2;
   localparam int DIST_W = 7;

   // Largest distance the response field carries
   localparam int DIST_MAX = (1 << DIST_W) - 1;

   // Similarity rule: similar when SIM_NUM*(maxlen-dist) >= SIM_DEN*maxlen
   localparam int SIM_NUM = 99;
   localparam int SIM_DEN = 79;
   localparam int SIM_K_W = 7;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_CALC
   } state_type;

   // Control that travels with each row token along the cell chain
   typedef struct packed {
      logic valid;
      logic last;
      logic init;
   } ctl_type;

endpackage

// ===== hdl/edsim_if.sv =====
interface edsim_req_if;
   logic                           valid;
   logic                           ready;
   logic [edsim_pkg::CMD_W-1:0]    cmd;
   logic [edsim_pkg::CH_W-1:0]     ch;

   modport source (output valid, output cmd, output ch, input ready);
   modport sink   (input valid, input cmd, input ch, output ready);
endinterface

interface edsim_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [edsim_pkg::DIST_W-1:0]   distance;
   logic                           similar;
   logic                           overflow;

   modport source (output valid, output distance, output similar, output overflow,
                   input ready);
   modport sink   (input valid, input distance, input similar, input overflow,
                   output ready);
endinterface

// ===== hdl/edit_distance_similarity_top.sv =====
// Append words take one cycle each and may be taken while a response word waits.
// Finish with an empty first string: the block skips the row run and goes to compare.
// Otherwise the response is loaded after the last of n+1 row tokens leaves the
// MAX_LEN-cell chain, n the first string's length.
// One finish at a time. Reset clears both lengths, the overflow flag and the
// cell occupancy at once; no clearing pass is needed.
module edit_distance_similarity_top #(
   parameter int MAX_LEN = 64
) (
   input  logic         clock,
   input  logic         reset,
   edsim_req_if.sink    req_chan,
   edsim_rsp_if.source  rsp_chan
);
   import edsim_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PW = LW + SIM_K_W;
   localparam int XW = LW + DIST_W;

   state_type           state_ff, state_in;
   logic [LW-1:0]       fst_len_ff;
   logic [LW-1:0]       sec_len_ff;
   logic                dropped_ff;
   logic [LW-1:0]       row_ff;
   logic [LW-1:0]       dist_ff;
   logic [CH_W-1:0]     rd_data_ff;
   logic [CH_W-1:0]     first_mem [MAX_LEN];
   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   rsp_dist_ff;
   logic                rsp_sim_ff;
   logic                rsp_ovf_ff;

   logic                req_acc;
   logic                app_first, app_second, app_drop;
   logic                fin_acc;
   logic                rsp_load;
   logic                run_end;
   logic                chain_done;
   ctl_type             bnd_ctl;
   ctl_type             chain_ctl;
   logic [LW-1:0]       chain_new;
   logic [LW-1:0]       max_len;
   logic [PW-1:0]       sim_lhs, sim_rhs;
   logic                sim_bit;
   logic [XW-1:0]       dist_wide;
   logic [DIST_W-1:0]   dist_sat;

   // Decode the request word
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc    = req_chan.valid && req_chan.ready;
   assign app_first  = req_acc && (req_chan.cmd == CMD_FIRST)
                       && (fst_len_ff != LW'(MAX_LEN));
   assign app_second = req_acc && (req_chan.cmd == CMD_SECOND)
                       && (sec_len_ff != LW'(MAX_LEN));
   assign app_drop   = req_acc
                       && (((req_chan.cmd == CMD_FIRST) && (fst_len_ff == LW'(MAX_LEN)))
                       || ((req_chan.cmd == CMD_SECOND) && (sec_len_ff == LW'(MAX_LEN))));
   assign fin_acc    = req_acc && (req_chan.cmd == CMD_FINISH);

   assign run_end    = (row_ff == fst_len_ff);
   assign chain_done = chain_ctl.valid && chain_ctl.last;

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and strobes
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (fin_acc) begin
               state_in = (fst_len_ff == '0) ? ST_CALC : ST_RUN;
            end
         end
         ST_RUN: begin
            if (run_end) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (chain_done) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Lengths and overflow flag; clear once the response is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         fst_len_ff <= '0;
         sec_len_ff <= '0;
         dropped_ff <= 1'b0;
      end else if (rsp_load) begin
         fst_len_ff <= '0;
         sec_len_ff <= '0;
         dropped_ff <= 1'b0;
      end else begin
         if (app_first) begin
            fst_len_ff <= fst_len_ff + LW'(1);
         end
         if (app_second) begin
            sec_len_ff <= sec_len_ff + LW'(1);
         end
         if (app_drop) begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // First string store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (app_first) begin
         first_mem[fst_len_ff[AW-1:0]] <= req_chan.ch;
      end
      rd_data_ff <= first_mem[row_ff[AW-1:0]];
   end

   // Row counter: row 0 primes the chain, rows 1..n carry first-string bytes
   always_ff @(posedge clock) begin
      if (fin_acc) begin
         row_ff <= '0;
      end else if (state_ff == ST_RUN) begin
         row_ff <= row_ff + LW'(1);
      end
   end

   // Boundary column of the distance matrix
   always_comb begin
      bnd_ctl.valid = (state_ff == ST_RUN);
      bnd_ctl.last  = run_end;
      bnd_ctl.init  = (row_ff == '0);
   end

   edsim_chain #(
      .MAX_LEN (MAX_LEN),
      .VAL_W   (LW)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .clear   (rsp_load),
      .load    (app_second),
      .load_ch (req_chan.ch),
      .in_ctl  (bnd_ctl),
      .in_ch   (rd_data_ff),
      .in_new  (row_ff),
      .in_diag (row_ff - LW'(1)),
      .out_ctl (chain_ctl),
      .out_new (chain_new)
   );

   // Capture the distance: from the chain end, or the second length alone
   always_ff @(posedge clock) begin
      if (fin_acc && (fst_len_ff == '0)) begin
         dist_ff <= sec_len_ff;
      end else if ((state_ff == ST_WAIT) && chain_done) begin
         dist_ff <= chain_new;
      end
   end

   // Similarity test and distance saturation
   always_comb begin
      max_len   = (fst_len_ff > sec_len_ff) ? fst_len_ff : sec_len_ff;
      sim_lhs   = PW'(max_len - dist_ff) * PW'(SIM_NUM);
      sim_rhs   = PW'(max_len) * PW'(SIM_DEN);
      if ((fst_len_ff == '0) && (sec_len_ff == '0)) begin
         sim_bit = 1'b1;
      end else if ((fst_len_ff == '0) || (sec_len_ff == '0)) begin
         sim_bit = 1'b0;
      end else begin
         sim_bit = (sim_lhs >= sim_rhs);
      end
      dist_wide = XW'(dist_ff);
      dist_sat  = (dist_wide > XW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : dist_wide[DIST_W-1:0];
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_dist_ff <= dist_sat;
         rsp_sim_ff  <= sim_bit;
         rsp_ovf_ff  <= dropped_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;
   assign rsp_chan.similar  = rsp_sim_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

   // A run only starts with a non-empty first string
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (fst_len_ff != '0))
      else $error("row run with empty first string");

   // The distance never exceeds the longer string
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (dist_ff <= max_len))
      else $error("distance beyond longer length");

   // A new response word only comes out of the compare state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CALC))
      else $error("response raised outside compare");

   // The last row token leaves the chain only while waiting for it
   a_chain_done: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> (state_ff == ST_WAIT))
      else $error("last row token outside wait");

endmodule

// ===== hdl/edsim_cell.sv =====
module edsim_cell #(
   parameter int VAL_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        load,
   input  logic [edsim_pkg::CH_W-1:0]  load_ch,
   input  logic                        load_occ,
   input  edsim_pkg::ctl_type          in_ctl,
   input  logic [edsim_pkg::CH_W-1:0]  in_ch,
   input  logic [VAL_W-1:0]            in_new,
   input  logic [VAL_W-1:0]            in_diag,
   output logic                        occ,
   output logic [edsim_pkg::CH_W-1:0]  chr,
   output edsim_pkg::ctl_type          out_ctl,
   output logic [edsim_pkg::CH_W-1:0]  out_ch,
   output logic [VAL_W-1:0]            out_new,
   output logic [VAL_W-1:0]            out_diag
);
   import edsim_pkg::*;

   logic                occ_ff;
   logic [CH_W-1:0]     char_ff;
   logic [VAL_W-1:0]    up_ff;
   ctl_type             out_ctl_ff;
   logic [CH_W-1:0]     out_ch_ff;
   logic [VAL_W-1:0]    out_new_ff;
   logic [VAL_W-1:0]    out_diag_ff;
   logic [VAL_W-1:0]    min_ul;
   logic [VAL_W-1:0]    min_all;
   logic [VAL_W-1:0]    val_in;

   // Work out this cell's entry of the current row
   always_comb begin
      min_ul  = (up_ff < in_new) ? up_ff : in_new;
      min_all = (min_ul < in_diag) ? min_ul : in_diag;
      if (in_ctl.init) begin
         val_in = in_new + VAL_W'(1);
      end else if (in_ch == char_ff) begin
         val_in = in_diag;
      end else begin
         val_in = min_all + VAL_W'(1);
      end
   end

   // Hold the character and its occupancy; shift on append, drop on clear
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (clear) begin
         occ_ff <= 1'b0;
      end else if (load) begin
         occ_ff <= load_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= load_ch;
      end
   end

   // Advance the token control every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else begin
         out_ctl_ff <= in_ctl;
      end
   end

   // Update the stored entry, or pass the token through an empty cell
   always_ff @(posedge clock) begin
      if (in_ctl.valid) begin
         out_ch_ff <= in_ch;
         if (occ_ff) begin
            out_new_ff  <= val_in;
            out_diag_ff <= up_ff;
            up_ff       <= val_in;
         end else begin
            out_new_ff  <= in_new;
            out_diag_ff <= in_diag;
         end
      end
   end

   assign occ      = occ_ff;
   assign chr      = char_ff;
   assign out_ctl  = out_ctl_ff;
   assign out_ch   = out_ch_ff;
   assign out_new  = out_new_ff;
   assign out_diag = out_diag_ff;

endmodule

// ===== hdl/edsim_chain.sv =====
module edsim_chain #(
   parameter int MAX_LEN = 64,
   parameter int VAL_W   = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        load,
   input  logic [edsim_pkg::CH_W-1:0]  load_ch,
   input  edsim_pkg::ctl_type          in_ctl,
   input  logic [edsim_pkg::CH_W-1:0]  in_ch,
   input  logic [VAL_W-1:0]            in_new,
   input  logic [VAL_W-1:0]            in_diag,
   output edsim_pkg::ctl_type          out_ctl,
   output logic [VAL_W-1:0]            out_new
);
   import edsim_pkg::*;

   ctl_type             ctl_w  [MAX_LEN+1];
   logic [CH_W-1:0]     ch_w   [MAX_LEN+1];
   logic [VAL_W-1:0]    new_w  [MAX_LEN+1];
   logic [VAL_W-1:0]    diag_w [MAX_LEN+1];
   logic                occ_w  [MAX_LEN+1];
   logic [CH_W-1:0]     chr_w  [MAX_LEN+1];

   // Boundary column feeds the left end; appends enter at the right end
   assign ctl_w[0]        = in_ctl;
   assign ch_w[0]         = in_ch;
   assign new_w[0]        = in_new;
   assign diag_w[0]       = in_diag;
   assign occ_w[MAX_LEN]  = 1'b1;
   assign chr_w[MAX_LEN]  = load_ch;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      edsim_cell #(
         .VAL_W (VAL_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .load     (load),
         .load_ch  (chr_w[k+1]),
         .load_occ (occ_w[k+1]),
         .in_ctl   (ctl_w[k]),
         .in_ch    (ch_w[k]),
         .in_new   (new_w[k]),
         .in_diag  (diag_w[k]),
         .occ      (occ_w[k]),
         .chr      (chr_w[k]),
         .out_ctl  (ctl_w[k+1]),
         .out_ch   (ch_w[k+1]),
         .out_new  (new_w[k+1]),
         .out_diag (diag_w[k+1])
      );
   end

   assign out_ctl = ctl_w[MAX_LEN];
   assign out_new = new_w[MAX_LEN];

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import edsim_pkg::*;

   localparam int MAX_LEN = 64;
   localparam int TARGET_WORDS = 1550;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              similar;
      logic              overflow;
   } reply_type;

   typedef enum int {
      EDIT_SUB,
      EDIT_DEL,
      EDIT_INS
   } edit_kind_type;

   // Tracks both strings and holds the replies still owed by the block
   class similarity_board_type;
      logic [CH_W-1:0] first_chars[MAX_LEN];
      logic [CH_W-1:0] second_chars[MAX_LEN];
      int              first_len;
      int              second_len;
      bit              dropped;
      reply_type       pending_replies[$];
      int              mismatches;
      int              failures;

      function new();
         first_len  = 0;
         second_len = 0;
         dropped    = 0;
         mismatches = 0;
         failures   = 0;
      endfunction

      // Single-row dynamic programme over the two stored strings
      function int levenshtein();
         int row[MAX_LEN+1];
         int diag;
         int up;
         int best;
         for (int j = 0; j <= second_len; j++) row[j] = j;
         for (int i = 1; i <= first_len; i++) begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= second_len; j++) begin
               up = row[j];
               if (first_chars[i-1] == second_chars[j-1]) begin
                  best = diag;
               end else begin
                  best = up;
                  if (row[j-1] < best) best = row[j-1];
                  if (diag < best) best = diag;
                  best = best + 1;
               end
               diag   = up;
               row[j] = best;
            end
         end
         return row[second_len];
      endfunction

      function void take_word(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch);
         reply_type r;
         int        edit_count;
         int        longest;
         case (cmd)
            CMD_FIRST: begin
               if (first_len < MAX_LEN) begin
                  first_chars[first_len] = ch;
                  first_len++;
               end else begin
                  dropped = 1'b1;
               end
            end
            CMD_SECOND: begin
               if (second_len < MAX_LEN) begin
                  second_chars[second_len] = ch;
                  second_len++;
               end else begin
                  dropped = 1'b1;
               end
            end
            CMD_FINISH: begin
               edit_count = levenshtein();
               if (first_len == 0 && second_len == 0) begin
                  r.similar = 1'b1;
               end else if (first_len == 0 || second_len == 0) begin
                  r.similar = 1'b0;
               end else begin
                  longest   = (first_len > second_len) ? first_len : second_len;
                  r.similar = (SIM_NUM * (longest - edit_count) >= SIM_DEN * longest);
               end
               r.distance = DIST_W'((edit_count > DIST_MAX) ? DIST_MAX : edit_count);
               r.overflow = dropped;
               pending_replies = {pending_replies, r};
               first_len  = 0;
               second_len = 0;
               dropped    = 1'b0;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_reply(logic [DIST_W-1:0] distance, logic similar, logic overflow);
         reply_type want;
         if (pending_replies.size() == 0) begin
            failures++;
            if (mismatches < 10)
               $display("unexpected reply: distance %0d similar %0b overflow %0b",
                        distance, similar, overflow);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (distance !== want.distance || similar !== want.similar ||
             overflow !== want.overflow) begin
            failures++;
            if (mismatches < 10)
               $display("reply mismatch: distance %0d/%0d similar %0b/%0b overflow %0b/%0b",
                        want.distance, distance, want.similar, similar,
                        want.overflow, overflow);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   edsim_req_if req_bus ();
   edsim_rsp_if rsp_bus ();

   edit_distance_similarity_top #(
      .MAX_LEN (MAX_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   similarity_board_type board = new();
   int words_sent = 0;
   bit quiet_requests = 1'b0;
   bit quiet_replies = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the block stops answering
   initial begin
      #20_000_000;
      $display("edit_distance_similarity_top test failed");
      $finish;
   end

   // Offer one request word after a random gap and hold it until taken
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch);
      int gap;
      gap = quiet_requests ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.ch    <= ch;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.take_word(cmd, ch);
      if (cmd != CMD_UNUSED) words_sent++;
   endtask

   function automatic logic [CH_W-1:0] pick_char(bit narrow);
      return narrow ? CH_W'(8'h61 + $urandom_range(0, 3)) : CH_W'($urandom_range(0, 255));
   endfunction

   // Load a pair of strings, often near copies of each other, then usually compare
   task automatic run_pair();
      logic [CH_W-1:0] first_q[$];
      logic [CH_W-1:0] second_q[$];
      int              n_first;
      int              n_second;
      int              mode;
      int              edits;
      int              pos;
      bit              narrow;
      bit              take_first;
      edit_kind_type   kind;
      mode   = $urandom_range(0, 99);
      narrow = ($urandom_range(0, 2) != 0);
      if (mode < 6) begin
         n_first  = $urandom_range(0, 3);
         n_second = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
      end else if (mode < 90) begin
         n_first  = $urandom_range(1, 10);
         n_second = $urandom_range(1, 10);
      end else begin
         n_first  = $urandom_range(50, 72);
         n_second = $urandom_range(50, 72);
      end
      for (int i = 0; i < n_first; i++) first_q = {first_q, pick_char(narrow)};
      if (n_first > 0 && n_second > 0 && $urandom_range(0, 1)) begin
         // derive the second string from the first with a few edits
         second_q = first_q;
         edits = $urandom_range(0, 4);
         for (int k = 0; k < edits; k++) begin
            pos  = (second_q.size() == 0) ? 0 : $urandom_range(0, second_q.size() - 1);
            kind = edit_kind_type'($urandom_range(0, 2));
            case (kind)
               EDIT_SUB: if (second_q.size() > 0) second_q[pos] = pick_char(narrow);
               EDIT_DEL: if (second_q.size() > 0) second_q.delete(pos);
               default:  second_q.insert(pos, pick_char(narrow));
            endcase
         end
      end else begin
         for (int i = 0; i < n_second; i++) second_q = {second_q, pick_char(narrow)};
      end
      // interleave the two strings, with the odd unused command as noise
      while (first_q.size() + second_q.size() > 0) begin
         if ($urandom_range(0, 99) < 3) send_word(CMD_UNUSED, pick_char(1'b0));
         take_first = (second_q.size() == 0) ||
                      (first_q.size() > 0 && $urandom_range(0, 1) == 1);
         if (take_first) send_word(CMD_FIRST, first_q.pop_front());
         else send_word(CMD_SECOND, second_q.pop_front());
      end
      // now and then leave the pair open so the next one piles on top
      if ($urandom_range(0, 99) < 96) send_word(CMD_FINISH, pick_char(1'b0));
   endtask

   // Take reply words after random stalls, some before and some after the offer
   initial begin : reply_sink
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) quiet_replies = !quiet_replies;
         stall = quiet_replies ? 0 : $urandom_range(0, 6);
         if (!quiet_replies && $urandom_range(0, 1) == 1) begin
            rsp_bus.ready <= 1'b0;
            do @(posedge clock); while (rsp_bus.valid !== 1'b1);
            @(negedge clock);
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
         end
         repeat (stall) @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         board.check_reply(rsp_bus.distance, rsp_bus.similar, rsp_bus.overflow);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int pair_count;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_FIRST;
      req_bus.ch    = '0;
      reset         = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // both strings empty
      send_word(CMD_FINISH, 8'h00);
      // only one string loaded, each side in turn
      send_word(CMD_FIRST, 8'h00);
      send_word(CMD_FINISH, 8'hFF);
      send_word(CMD_SECOND, 8'hFF);
      send_word(CMD_FINISH, 8'h00);
      // equal strings at the byte extremes
      send_word(CMD_FIRST, 8'h00);
      send_word(CMD_FIRST, 8'hFF);
      send_word(CMD_SECOND, 8'h00);
      send_word(CMD_SECOND, 8'hFF);
      send_word(CMD_FINISH, 8'h55);
      // one substitution on single bytes
      send_word(CMD_FIRST, 8'hAA);
      send_word(CMD_SECOND, 8'h55);
      send_word(CMD_FINISH, 8'hAA);
      // unused command changes nothing
      send_word(CMD_UNUSED, 8'hFF);
      send_word(CMD_FINISH, 8'h00);

      pair_count = 0;
      while (words_sent < TARGET_WORDS) begin
         // hold off now and then until every reply is in
         if (pair_count % 25 == 3) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (board.outstanding() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 7) == 0) quiet_requests = !quiet_requests;
         run_pair();
         pair_count++;
      end
      send_word(CMD_FINISH, 8'h00);
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, then watch for stray replies
      while (board.outstanding() != 0) @(posedge clock);
      repeat (2 * MAX_LEN + 16) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("edit_distance_similarity_top test passed");
      end else begin
         $display("edit_distance_similarity_top test failed");
      end
      $finish;
   end

endmodule

// ===== edit_distance_similarity_top.f =====
hdl/edsim_pkg.sv
hdl/edsim_if.sv
hdl/edsim_cell.sv
hdl/edsim_chain.sv
hdl/edit_distance_similarity_top.sv
test/tb_top.sv
